FILE: hdl/ufa_pkg.sv
// Shared types and constants for the UTF-8 text filter and appender.
// No dependencies; every other file in this block imports it.
package ufa_pkg;

    // One input beat: tag, raw byte and segment marker.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       segment_end;
    } item_t;

    // One result beat: appended byte, character count and end-of-run flag.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] char_count;
        logic       last_of_run;
    } result_t;

    // All results caused by one input beat, as handed from front to back.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [7:0]      shown;
    } group_t;

    // Configuration map.
    localparam int         PADDR_W         = 3;
    localparam logic [2:0] ADDR_MAX_CHARS  = 3'd0;
    localparam logic [7:0] MAX_CHARS_RESET = 8'd32;

endpackage

FILE: hdl/utf8_text_filter_appender.sv
// UTF-8 text filter and appender, top level. Takes one byte beat per clock
// while full is low; a beat's results (zero to four bytes) appear on the
// result side from the next cycle on, one beat per cycle while pop is high, through a queue
// of QUEUE_DEPTH byte groups. full rises only when that queue holds
// QUEUE_DEPTH groups. With pop held high at most four groups ever wait
// (a four-byte character followed by single-byte characters), so with the
// default depth of five the block sustains one input beat per cycle; the
// back part's one-byte-per-cycle output sets that rate.
// max_chars is written over the APB port at byte address 0.
// Depends on ufa_pkg, ufa_front, ufa_queue and ufa_back.
module utf8_text_filter_appender
    import ufa_pkg::*;
#(
    parameter int COUNT_WIDTH = 8,
    parameter int QUEUE_DEPTH = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  item_t              item,
    output logic               empty,
    input  logic               pop,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] max_chars_reg;
    logic       accept;
    logic       grp_valid;
    group_t     grp, head;
    logic       head_empty, head_pop;
    logic       cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_MAX_CHARS);
    assign prdata    = (paddr == ADDR_MAX_CHARS) ? {24'd0, max_chars_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_chars_reg <= MAX_CHARS_RESET;
        else if (cfg_write)
            max_chars_reg <= pwdata[7:0];
    end

    assign accept = push && !full;

    ufa_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .max_chars (max_chars_reg),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    ufa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && grp_valid),
        .push_data (grp),
        .full      (full),
        .pop       (head_pop),
        .head      (head),
        .empty     (head_empty)
    );

    ufa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

FILE: hdl/ufa_front.sv
// Front part: classifies each input beat, tracks the pending UTF-8 sequence
// and the character count, and forms the group of bytes to append.
// Depends on ufa_pkg.
module ufa_front
    import ufa_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  logic [7:0] max_chars,
    output logic       grp_valid,
    output group_t     grp
);

    localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

    localparam logic [7:0] MASK_TOP   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CODE_DEL   = 8'h7F;

    logic [7:0]             pend_bytes_reg [3];
    logic [7:0]             pend_bytes_next [3];
    logic [2:0]             pend_len_reg, pend_len_next;
    logic [1:0]             pend_have_reg, pend_have_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic       typed, seg, is_cont, at_limit, handled;
    logic [7:0] b;
    logic [2:0] lead_len;
    logic [2:0] add_main;
    logic [1:0] add_seg;
    logic [2:0] add_total;
    logic [COUNT_WIDTH:0]   sum_mid, sum_fin;
    logic [COUNT_WIDTH-1:0] count_mid, count_fin;
    logic [CMP_W-1:0]       count_mid_ext;
    logic [3:0][7:0]        grp_bytes;
    logic [1:0]             grp_last_idx;
    logic [7:0]             grp_shown;

    // Length of the sequence a lead byte opens, zero when it is not a lead.
    function automatic logic [2:0] lead_class(input logic [7:0] v);
        logic [2:0] len;
        priority if ((v & MASK_TOP) == 8'h00)         len = 3'd1;
        else if ((v & MASK_LEAD2) == CODE_LEAD2)      len = 3'd2;
        else if ((v & MASK_LEAD3) == CODE_LEAD3)      len = 3'd3;
        else if ((v & MASK_LEAD4) == CODE_LEAD4)      len = 3'd4;
        else                                          len = 3'd0;
        return len;
    endfunction

    assign typed    = item.func;
    assign seg      = item.segment_end;
    assign b        = item.data_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign at_limit = (CMP_W'(count_reg) >= CMP_W'(max_chars));
    assign handled  = (pend_len_reg != 3'd0) && is_cont;
    assign lead_len = lead_class(b);

    // Sequence tracking and byte selection for one beat.
    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_len_next   = pend_len_reg;
        pend_have_next  = pend_have_reg;
        add_main        = 3'd0;
        grp_valid       = 1'b0;
        grp_bytes       = {4{b}};
        grp_last_idx    = 2'd0;

        // A pending sequence is continued, completed or cut.
        if (pend_len_reg != 3'd0)
        begin
            if (is_cont)
            begin
                if (typed && at_limit)
                begin
                    pend_len_next  = 3'd0;
                    pend_have_next = 2'd0;
                end
                else if ({1'b0, pend_have_reg} + 3'd1 >= pend_len_reg)
                begin
                    if (typed)
                    begin
                        grp_valid    = 1'b1;
                        grp_last_idx = pend_have_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            if (2'(i) < pend_have_reg)
                                grp_bytes[i] = pend_bytes_reg[i];
                        end
                    end
                    add_main       = 3'd1;
                    pend_len_next  = 3'd0;
                    pend_have_next = 2'd0;
                end
                else if (pend_have_reg != 2'd3)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) == pend_have_reg)
                            pend_bytes_next[i] = b;
                    end
                    pend_have_next = pend_have_reg + 2'd1;
                end
                else
                begin
                    pend_len_next  = 3'd0;
                    pend_have_next = 2'd0;
                end
            end
            else
            begin
                if (!typed)
                    add_main = {1'b0, pend_have_reg};
                pend_len_next  = 3'd0;
                pend_have_next = 2'd0;
            end
        end

        // The byte taken as a lead.
        if (!handled && !(typed && at_limit))
        begin
            if (lead_len == 3'd0)
            begin
                if (!typed)
                    add_main = add_main + 3'd1;
            end
            else if (lead_len == 3'd1)
            begin
                if (!typed)
                    add_main = add_main + 3'd1;
                else if (b >= CTRL_LIMIT && b != CODE_DEL)
                begin
                    grp_valid    = 1'b1;
                    grp_last_idx = 2'd0;
                    add_main     = add_main + 3'd1;
                end
            end
            else
            begin
                pend_bytes_next[0] = b;
                pend_have_next     = 2'd1;
                pend_len_next      = lead_len;
            end
        end
    end

    // Count after the beat, and after the segment flush.
    assign add_seg   = (seg && !typed && pend_len_next != 3'd0) ? pend_have_next : 2'd0;
    assign add_total = add_main + {1'b0, add_seg};
    assign sum_mid   = {1'b0, count_reg} + (COUNT_WIDTH + 1)'(add_main);
    assign sum_fin   = {1'b0, count_reg} + (COUNT_WIDTH + 1)'(add_total);
    assign count_mid = sum_mid[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum_mid[COUNT_WIDTH-1:0];
    assign count_fin = sum_fin[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum_fin[COUNT_WIDTH-1:0];
    assign count_next = (seg && typed) ? '0 : count_fin;

    assign count_mid_ext = CMP_W'(count_mid);
    assign grp_shown = (count_mid_ext > CMP_W'(8'hFF)) ? 8'hFF : count_mid_ext[7:0];

    // Group handed to the queue.
    assign grp = '{bytes: grp_bytes, last_idx: grp_last_idx, shown: grp_shown};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_len_reg  <= 3'd0;
            pend_have_reg <= 2'd0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            pend_len_reg  <= seg ? 3'd0 : pend_len_next;
            pend_have_reg <= seg ? 2'd0 : pend_have_next;
            count_reg     <= count_next;
        end
    end

    // Pending bytes hold only payload.
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_bytes_reg <= pend_bytes_next;
    end

endmodule

FILE: hdl/ufa_queue.sv
// Short queue of byte groups between the front and back parts.
// Depends on ufa_pkg.
module ufa_queue
    import ufa_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_data,
    output logic   full,
    input  logic   pop,
    output group_t head,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/ufa_back.sv
// Back part: walks through the head group of the queue and delivers one
// result beat per byte. Depends on ufa_pkg.
module ufa_back
    import ufa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  group_t  head,
    input  logic    head_empty,
    output logic    head_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign last    = (idx_reg == head.last_idx);
    assign empty   = head_empty;

    assign result.out_byte    = head.bytes[idx_reg];
    assign result.char_count  = head.shown;
    assign result.last_of_run = last;

    // Release the group after its last byte goes out.
    assign head_pop = pop && !head_empty && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop && !head_empty)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

FILE: hdl/ufa_checker.sv
// Port-level checks for the UTF-8 text filter and appender, bound to the
// top level. Depends on ufa_pkg.
module ufa_checker
    import ufa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input result_t            result,
    input logic               pready
);

    // A waiting result beat holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while waiting");

    // Results only appear after an input beat has been taken.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without an accepted input beat");

    // Every appended byte belongs to a counted character.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.char_count != 8'd0))
        else $error("result shows a zero character count");

    // An ASCII byte is a whole printable character.
    a_ascii_printable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.out_byte[7]) |->
        (result.last_of_run && result.out_byte >= 8'h20 && result.out_byte != 8'h7F))
        else $error("control byte or split ASCII character delivered");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind utf8_text_filter_appender ufa_checker u_ufa_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 text filter and appender.
// Depends on ufa_pkg and utf8_text_filter_appender; nothing else is read.
module tb_top;
    import ufa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 12;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    item_t               beat_in = '0;
    logic                empty;
    logic                pop = 1'b0;
    result_t             beat_out;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Input beats still to be sent, and appended bytes still to come out.
    item_t   beats_q[$];
    result_t appended_q[$];

    // Mirror of the block: limit register, partial sequence and character count.
    logic [7:0] lim_chars = MAX_CHARS_RESET;
    logic [7:0] seq_bytes [3];
    logic [2:0] seq_len = 3'd0;
    logic [1:0] seq_have = 2'd0;
    logic [7:0] char_tally = 8'd0;

    int send_idle_pct = 35;
    int recv_idle_pct = 65;
    int fault_cnt = 0;
    int cycle_cnt = 0;

    utf8_text_filter_appender i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (beat_in),
        .empty   (empty),
        .pop     (pop),
        .result  (beat_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Length of the sequence that a lead byte opens; zero marks an invalid lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (b[7] == 1'b0)
            return 3'd1;
        if (b[7:5] == 3'b110)
            return 3'd2;
        if (b[7:4] == 4'b1110)
            return 3'd3;
        if (b[7:3] == 5'b11110)
            return 3'd4;
        return 3'd0;
    endfunction

    // Add characters to the count, holding at the top value.
    task automatic tally_add(input int n);
        int sum;
        begin
            sum = int'(char_tally) + n;
            char_tally = (sum > 255) ? 8'hFF : sum[7:0];
        end
    endtask

    task automatic drop_seq();
        seq_len = 3'd0;
        seq_have = 2'd0;
    endtask

    // Work out the bytes that one accepted beat appends and queue them.
    task automatic predict_append(input item_t it);
        logic [7:0] emit [4];
        int         n_emit;
        int         i;
        logic       handled;
        logic       at_limit;
        logic [2:0] sz;
        logic [7:0] b;
        result_t    r;
        begin
            b = it.data_byte;
            n_emit = 0;
            handled = 1'b0;
            at_limit = (char_tally >= lim_chars);

            // A pending sequence is continued, completed or abandoned first.
            if (seq_len != 3'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    handled = 1'b1;
                    if (it.func && at_limit)
                        drop_seq();
                    else if ({1'b0, seq_have} + 3'd1 >= seq_len)
                    begin
                        if (it.func)
                        begin
                            for (i = 0; i < int'(seq_have) && i < 3; i++)
                            begin
                                emit[n_emit] = seq_bytes[i];
                                n_emit++;
                            end
                            emit[n_emit] = b;
                            n_emit++;
                        end
                        tally_add(1);
                        drop_seq();
                    end
                    else if (seq_have < 2'd3)
                    begin
                        seq_bytes[seq_have] = b;
                        seq_have++;
                    end
                    else
                        drop_seq();
                end
                else
                begin
                    if (!it.func)
                        tally_add(int'(seq_have));
                    drop_seq();
                end
            end

            // Otherwise the byte is examined as a lead.
            if (!handled)
            begin
                sz = lead_len(b);
                if (it.func && at_limit)
                    ;
                else if (sz == 3'd0)
                begin
                    if (!it.func)
                        tally_add(1);
                end
                else if (sz == 3'd1)
                begin
                    if (!it.func)
                        tally_add(1);
                    else if (b >= 8'h20 && b != 8'h7F)
                    begin
                        emit[n_emit] = b;
                        n_emit++;
                        tally_add(1);
                    end
                end
                else
                begin
                    seq_bytes[0] = b;
                    seq_have = 2'd1;
                    seq_len = sz;
                end
            end

            for (i = 0; i < n_emit; i++)
            begin
                r.out_byte = emit[i];
                r.char_count = char_tally;
                r.last_of_run = (i == n_emit - 1);
                appended_q = {appended_q, r};
            end

            // Segment end flushes a partial sequence; a typed segment clears the count.
            if (it.segment_end)
            begin
                if (seq_len != 3'd0)
                begin
                    if (!it.func)
                        tally_add(int'(seq_have));
                    drop_seq();
                end
                if (it.func)
                    char_tally = 8'd0;
            end
        end
    endtask

    // Driver: present the next pending beat at the falling edge, idling at random.
    always @(negedge clk)
    begin
        if (rst_n && beats_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
        begin
            push <= 1'b1;
            beat_in <= beats_q[0];
        end
        else
            push <= 1'b0;
    end

    // A beat taken at this edge is predicted and retired from the send queue.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_append(beat_in);
            void'(beats_q.pop_front());
        end
    end

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Monitor: every result beat taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (appended_q.size() == 0)
            begin
                $display("%0t: unexpected result, got byte %h count %0d last %b",
                         $time, beat_out.out_byte, beat_out.char_count,
                         beat_out.last_of_run);
                fault_cnt++;
            end
            else
            begin
                want = appended_q.pop_front();
                if (beat_out !== want)
                begin
                    $display("%0t: mismatch, expected byte %h count %0d last %b",
                             $time, want.out_byte, want.char_count, want.last_of_run);
                    $display("%0t:           got      byte %h count %0d last %b",
                             $time, beat_out.out_byte, beat_out.char_count,
                             beat_out.last_of_run);
                    fault_cnt++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic item_t make_beat(input logic f, input logic [7:0] b, input logic s);
        item_t it;
        it.func = f;
        it.data_byte = b;
        it.segment_end = s;
        return it;
    endfunction

    task automatic add_beat(input logic f, input logic [7:0] b, input logic s);
        beats_q = {beats_q, make_beat(f, b, s)};
    endtask

    // Write the limit register, mirror it, and read it back.
    task automatic write_limit(input logic [7:0] lim);
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_MAX_CHARS;
            pwdata <= {24'd0, lim};
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            lim_chars = lim;
            @(negedge clk);
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata[7:0] !== lim)
            begin
                $display("%0t: limit readback, expected %h got %h", $time, lim, prdata[7:0]);
                fault_cnt++;
            end
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Hold the sender until every beat is out and every result has come back.
    task automatic settle();
        begin
            while (beats_q.size() != 0 || appended_q.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // First byte of a character of the given length with random payload bits.
    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            1: return 8'($urandom_range(127, 0));
            2: return 8'hC0 | 8'($urandom_range(31, 0));
            3: return 8'hE0 | 8'($urandom_range(15, 0));
            default: return 8'hF0 | 8'($urandom_range(7, 0));
        endcase
    endfunction

    // One segment: mostly well-formed characters, some noise and cut sequences,
    // with an occasional byte under the other tag.
    task automatic queue_segment(inout int added);
        item_t      seg_q[$];
        logic       typed;
        int         chars;
        int         pick;
        int         len;
        int         cut;
        int         k;
        logic [7:0] b;
        begin
            typed = 1'($urandom_range(1, 0));
            chars = $urandom_range(12, 1);
            repeat (chars)
            begin
                pick = $urandom_range(9, 0);
                if (pick == 0)
                    seg_q = {seg_q, make_beat(typed ^ ($urandom_range(19, 0) == 0),
                                              8'($urandom_range(255, 0)), 1'b0)};
                else
                begin
                    len = $urandom_range(4, 1);
                    cut = (pick == 1 && len > 1) ? $urandom_range(len - 1, 1) : len;
                    for (k = 0; k < cut; k++)
                    begin
                        b = (k == 0) ? lead_byte(len) : (8'h80 | 8'($urandom_range(63, 0)));
                        seg_q = {seg_q, make_beat(typed ^ ($urandom_range(19, 0) == 0),
                                                  b, 1'b0)};
                    end
                end
            end
            seg_q[seg_q.size() - 1].segment_end = 1'b1;
            added += seg_q.size();
            beats_q = {beats_q, seg_q};
        end
    endtask

    task automatic run_random(input logic [7:0] lim, input int n_items);
        int added;
        begin
            settle();
            write_limit(lim);
            added = 0;
            while (added < n_items)
                queue_segment(added);
        end
    endtask

    initial
    begin
        int k;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset limit.
        // Existing text: ASCII, invalid lead, stray continuation, a cut sequence,
        // and a partial sequence flushed by the segment end.
        add_beat(1'b0, 8'h41, 1'b0);
        add_beat(1'b0, 8'hFF, 1'b0);
        add_beat(1'b0, 8'h80, 1'b0);
        add_beat(1'b0, 8'hC3, 1'b0);
        add_beat(1'b0, 8'h28, 1'b0);
        add_beat(1'b0, 8'hF0, 1'b0);
        add_beat(1'b0, 8'h9F, 1'b1);
        // Typed text: control bytes, top printable, two to four byte characters.
        add_beat(1'b1, 8'h00, 1'b0);
        add_beat(1'b1, 8'h7F, 1'b0);
        add_beat(1'b1, 8'h7E, 1'b0);
        add_beat(1'b1, 8'hC3, 1'b0);
        add_beat(1'b1, 8'hA9, 1'b0);
        add_beat(1'b1, 8'hE2, 1'b0);
        add_beat(1'b1, 8'h82, 1'b0);
        add_beat(1'b1, 8'hAC, 1'b0);
        add_beat(1'b1, 8'hF0, 1'b0);
        add_beat(1'b1, 8'h9F, 1'b0);
        add_beat(1'b1, 8'h98, 1'b0);
        add_beat(1'b1, 8'h80, 1'b0);
        // Typed sequence cut by an ASCII byte, then a tag switch mid-sequence.
        add_beat(1'b1, 8'hE2, 1'b0);
        add_beat(1'b1, 8'h41, 1'b0);
        add_beat(1'b1, 8'hC3, 1'b0);
        add_beat(1'b0, 8'hA9, 1'b0);
        add_beat(1'b1, 8'h20, 1'b1);

        // Limit at its top: a long run of existing text drives the count to
        // saturation, then random segments follow.
        settle();
        write_limit(8'hFF);
        for (k = 0; k < 256; k++)
            add_beat(1'b0, 8'($urandom_range(126, 32)), 1'b0);
        add_beat(1'b0, 8'h41, 1'b1);
        add_beat(1'b1, 8'h41, 1'b1);
        run_random(8'hFF, 25);

        // Limit zero: every typed byte is dropped.
        run_random(8'h00, 12);

        send_idle_pct = 65;
        recv_idle_pct = 35;
        run_random(8'd5, 20);
        run_random(8'd16, 18);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(8'($urandom_range(254, 1)), 25);

        settle();
        repeat (20) @(posedge clk);
        if (appended_q.size() != 0)
        begin
            $display("%0t: expected %0d more results, got 0", $time, appended_q.size());
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/ufa_pkg.sv
hdl/ufa_front.sv
hdl/ufa_queue.sv
hdl/ufa_back.sv
hdl/utf8_text_filter_appender.sv
hdl/ufa_checker.sv
dv/tb_top.sv
